### hw/rtl/ofrt_pkg.sv
package ofrt_pkg;

  localparam int TableEntries = 16;
  localparam int SectorCount  = 1024;
  localparam int CountBits    = 8;
  localparam int QueueDepth   = 2;

  localparam int SlotW      = $clog2(TableEntries);
  localparam int SectorW    = 10;
  localparam int SlotFieldW = 4;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    KIND_OPEN   = 2'd0,
    KIND_CLOSE  = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_PENDING   = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_OPEN  = 3'd3,
    ST_SATURATED = 3'd4
  } status_e;

  // classified request as it travels from front to back
  typedef enum logic [2:0] {
    OP_NOP    = 3'd0,
    OP_BAD    = 3'd1,
    OP_OPEN   = 3'd2,
    OP_CLOSE  = 3'd3,
    OP_REMOVE = 3'd4
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [SectorW-1:0] sector;
  } req_t;

  typedef enum logic [1:0] {
    BS_IDLE = 2'd0,
    BS_SCAN = 2'd1,
    BS_EXEC = 2'd2
  } back_state_e;

endpackage

### hw/rtl/ofrt_front.sv
module ofrt_front (
  input  logic [1:0]                  kind_i,
  input  logic [ofrt_pkg::SectorW-1:0] sector_i,
  output ofrt_pkg::req_t              req_o
);

  logic in_range;

  // sector count may exceed the field range, so compare at 17 bits, wider than the 10-bit field
  assign in_range = {7'b0, sector_i} < 17'(ofrt_pkg::SectorCount);

  always_comb begin
    req_o.sector = sector_i;
    case (kind_i)
      ofrt_pkg::KIND_OPEN:   req_o.op = in_range ? ofrt_pkg::OP_OPEN   : ofrt_pkg::OP_BAD;
      ofrt_pkg::KIND_CLOSE:  req_o.op = in_range ? ofrt_pkg::OP_CLOSE  : ofrt_pkg::OP_BAD;
      ofrt_pkg::KIND_REMOVE: req_o.op = in_range ? ofrt_pkg::OP_REMOVE : ofrt_pkg::OP_BAD;
      default:               req_o.op = ofrt_pkg::OP_NOP;
    endcase
  end

endmodule

### hw/rtl/ofrt_queue.sv
module ofrt_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ofrt_pkg::req_t push_req_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output ofrt_pkg::req_t pop_req_o
);

  ofrt_pkg::req_t                 mem_q [ofrt_pkg::QueueDepth];
  logic [ofrt_pkg::QPtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [ofrt_pkg::QCntW-1:0]     cnt_q;

  assign full_o    = cnt_q == ofrt_pkg::QCntW'(ofrt_pkg::QueueDepth);
  assign empty_o   = cnt_q == '0;
  assign pop_req_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == ofrt_pkg::QPtrW'(ofrt_pkg::QueueDepth - 1)) ?
                    '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == ofrt_pkg::QPtrW'(ofrt_pkg::QueueDepth - 1)) ?
                    '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_req_i;
    end
  end

endmodule

### hw/rtl/ofrt_back.sv
module ofrt_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           empty_i,
  input  ofrt_pkg::req_t                 req_i,
  output logic                           pop_o,
  output logic                           done_o,
  output logic [2:0]                     status_o,
  output logic [ofrt_pkg::SlotFieldW-1:0] slot_o,
  output logic                           remove_now_o
);

  localparam logic [ofrt_pkg::CountBits-1:0] MaxCount = '1;
  localparam logic [ofrt_pkg::CountBits-1:0] OneCount = ofrt_pkg::CountBits'(1);
  localparam logic [ofrt_pkg::SlotW-1:0]     LastIdx  = ofrt_pkg::SlotW'(ofrt_pkg::TableEntries - 1);

  ofrt_pkg::back_state_e state_q, state_d;

  logic [ofrt_pkg::TableEntries-1:0] valid_q;
  logic [ofrt_pkg::SectorW-1:0]      sector_mem [ofrt_pkg::TableEntries];
  logic [ofrt_pkg::CountBits-1:0]    count_mem  [ofrt_pkg::TableEntries];
  logic                              pend_mem   [ofrt_pkg::TableEntries];

  ofrt_pkg::req_t               cur_q;
  logic [ofrt_pkg::SlotW-1:0]   idx_q;
  logic                         hit_q, free_q;
  logic [ofrt_pkg::SlotW-1:0]   hit_idx_q, free_idx_q;
  logic [ofrt_pkg::CountBits-1:0] hit_cnt_q;
  logic                         hit_pend_q;

  logic                         done_q, rm_q;
  ofrt_pkg::status_e            status_q;
  logic [ofrt_pkg::SlotFieldW-1:0] slot_q;

  // execute-cycle results and write-back controls
  ofrt_pkg::status_e              res_status;
  logic [ofrt_pkg::SlotW-1:0]     res_slot;
  logic                           res_rm;
  logic [ofrt_pkg::SlotW-1:0]     wr_idx;
  logic                           wr_valid_en, wr_valid_val;
  logic                           wr_sector_en;
  logic                           wr_count_en;
  logic [ofrt_pkg::CountBits-1:0] wr_count_val;
  logic                           wr_pend_en, wr_pend_val;
  logic                           needs_scan;

  assign needs_scan = req_i.op == ofrt_pkg::OP_OPEN || req_i.op == ofrt_pkg::OP_CLOSE ||
                      req_i.op == ofrt_pkg::OP_REMOVE;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ofrt_pkg::BS_IDLE: begin
        if (!empty_i) begin
          state_d = needs_scan ? ofrt_pkg::BS_SCAN : ofrt_pkg::BS_EXEC;
        end
      end
      ofrt_pkg::BS_SCAN: begin
        if (idx_q == LastIdx) begin
          state_d = ofrt_pkg::BS_EXEC;
        end
      end
      ofrt_pkg::BS_EXEC: state_d = ofrt_pkg::BS_IDLE;
      default:           state_d = ofrt_pkg::BS_IDLE;
    endcase
  end

  always_comb begin
    pop_o        = 1'b0;
    res_status   = ofrt_pkg::ST_OK;
    res_slot     = '0;
    res_rm       = 1'b0;
    wr_idx       = hit_idx_q;
    wr_valid_en  = 1'b0;
    wr_valid_val = 1'b0;
    wr_sector_en = 1'b0;
    wr_count_en  = 1'b0;
    wr_count_val = hit_cnt_q;
    wr_pend_en   = 1'b0;
    wr_pend_val  = 1'b0;
    case (state_q)
      ofrt_pkg::BS_IDLE: pop_o = !empty_i;
      ofrt_pkg::BS_EXEC: begin
        case (cur_q.op)
          ofrt_pkg::OP_BAD: res_status = ofrt_pkg::ST_NOT_OPEN;
          ofrt_pkg::OP_OPEN: begin
            if (hit_q) begin
              if (hit_pend_q) begin
                res_status = ofrt_pkg::ST_PENDING;
              end else if (hit_cnt_q == MaxCount) begin
                res_status = ofrt_pkg::ST_SATURATED;
              end else begin
                wr_count_en  = 1'b1;
                wr_count_val = hit_cnt_q + 1'b1;
                res_slot     = hit_idx_q;
              end
            end else if (free_q) begin
              // claim the lowest free slot
              wr_idx       = free_idx_q;
              wr_valid_en  = 1'b1;
              wr_valid_val = 1'b1;
              wr_sector_en = 1'b1;
              wr_count_en  = 1'b1;
              wr_count_val = OneCount;
              wr_pend_en   = 1'b1;
              wr_pend_val  = 1'b0;
              res_slot     = free_idx_q;
            end else begin
              res_status = ofrt_pkg::ST_FULL;
            end
          end
          ofrt_pkg::OP_CLOSE: begin
            if (!hit_q) begin
              res_status = ofrt_pkg::ST_NOT_OPEN;
            end else if (hit_cnt_q > OneCount) begin
              wr_count_en  = 1'b1;
              wr_count_val = hit_cnt_q - 1'b1;
              res_slot     = hit_idx_q;
            end else begin
              // last close: free the slot
              wr_valid_en  = 1'b1;
              wr_valid_val = 1'b0;
              res_rm       = hit_pend_q;
              res_slot     = hit_idx_q;
            end
          end
          ofrt_pkg::OP_REMOVE: begin
            if (!hit_q) begin
              res_rm = 1'b1;
            end else begin
              wr_pend_en  = 1'b1;
              wr_pend_val = 1'b1;
              res_slot    = hit_idx_q;
            end
          end
          default: res_status = ofrt_pkg::ST_OK;
        endcase
      end
      default: pop_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ofrt_pkg::BS_IDLE;
      valid_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= state_q == ofrt_pkg::BS_EXEC;
      if (wr_valid_en) begin
        valid_q[wr_idx] <= wr_valid_val;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_sector_en) begin
      sector_mem[wr_idx] <= cur_q.sector;
    end
    if (wr_count_en) begin
      count_mem[wr_idx] <= wr_count_val;
    end
    if (wr_pend_en) begin
      pend_mem[wr_idx] <= wr_pend_val;
    end
  end

  // scan one entry per cycle for a sector match and the lowest free slot
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q  <= req_i;
      idx_q  <= '0;
      hit_q  <= 1'b0;
      free_q <= 1'b0;
    end else if (state_q == ofrt_pkg::BS_SCAN) begin
      idx_q <= idx_q + 1'b1;
      if (valid_q[idx_q] && sector_mem[idx_q] == cur_q.sector) begin
        hit_q      <= 1'b1;
        hit_idx_q  <= idx_q;
        hit_cnt_q  <= count_mem[idx_q];
        hit_pend_q <= pend_mem[idx_q];
      end
      if (!valid_q[idx_q] && !free_q) begin
        free_q     <= 1'b1;
        free_idx_q <= idx_q;
      end
    end
    if (state_q == ofrt_pkg::BS_EXEC) begin
      status_q <= res_status;
      slot_q   <= ofrt_pkg::SlotFieldW'(res_slot);
      rm_q     <= res_rm;
    end
  end

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign slot_o       = slot_q;
  assign remove_now_o = rm_q;

endmodule

### hw/rtl/open_file_refcount_table.sv
// Open file table with reference counts, keyed by the disk sector of the file header.
// Request channel: drive kind_i and sector_i with start_i high; the word is taken at
// the rising edge where start_i is high and busy_o is low. kind 0 opens, 1 closes,
// 2 requests removal, 3 does nothing.
// Result channel: done_o is high for exactly one cycle with status_o, slot_o and
// remove_now_o; the receiver must take it then, there is no back pressure.
// Every request gives exactly one result, in request order.
// Flow for open, close and remove with the back end idle: a dispatch state that pops the
// queue, a scan of every table entry, an execute state, then an output register; invalid
// sectors and kind 3 skip the scan.
// The back end handles one request at a time and scans one table entry per cycle. A
// two-word queue in front lets new requests be accepted while the back end scans;
// busy_o rises when it is full.
// Reset empties the table and the queue; no clearing pass is needed.
module open_file_refcount_table (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [1:0]                      kind_i,
  input  logic [ofrt_pkg::SectorW-1:0]    sector_i,
  output logic                            done_o,
  output logic [2:0]                      status_o,
  output logic [ofrt_pkg::SlotFieldW-1:0] slot_o,
  output logic                            remove_now_o
);

  ofrt_pkg::req_t front_req, back_req;
  logic           q_full, q_empty, q_pop, q_push;

  assign busy_o = q_full;
  assign q_push = start_i && !q_full;

  ofrt_front u_front (
    .kind_i   (kind_i),
    .sector_i (sector_i),
    .req_o    (front_req)
  );

  ofrt_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_req_i (front_req),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .pop_req_o  (back_req)
  );

  ofrt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (q_empty),
    .req_i        (back_req),
    .pop_o        (q_pop),
    .done_o       (done_o),
    .status_o     (status_o),
    .slot_o       (slot_o),
    .remove_now_o (remove_now_o)
  );

endmodule

### test/ofrt_table_check.sv
module ofrt_table_check
  import ofrt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  busy_i,
  input  logic [1:0]            kind_i,
  input  logic [SectorW-1:0]    sector_i,
  input  logic                  done_i,
  input  logic [2:0]            status_i,
  input  logic [SlotFieldW-1:0] slot_i,
  input  logic                  remove_now_i,
  output int                    errors_o,
  output int                    waiting_o,
  output logic [4:0]            status_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxCount = (1 << CountBits) - 1;

  typedef struct packed {
    status_e               status;
    logic [SlotFieldW-1:0] slot;
    logic                  remove_now;
  } outcome_t;

  logic                 tbl_valid  [TableEntries];
  logic [SectorW-1:0]   tbl_sector [TableEntries];
  logic [CountBits-1:0] tbl_count  [TableEntries];
  logic                 tbl_marked [TableEntries];
  outcome_t             outcome_q[$];

  function automatic int find_entry(logic [SectorW-1:0] sec);
    for (int i = 0; i < TableEntries; i++) begin
      if (tbl_valid[i] && tbl_sector[i] == sec) return i;
    end
    return -1;
  endfunction

  function automatic int find_free_slot();
    for (int i = 0; i < TableEntries; i++) begin
      if (!tbl_valid[i]) return i;
    end
    return -1;
  endfunction

  // update the table copy and return what the block must answer
  function automatic outcome_t apply_request(kind_e kind, logic [SectorW-1:0] sec);
    outcome_t res;
    int s;
    res.status     = ST_OK;
    res.slot       = '0;
    res.remove_now = 1'b0;
    if (kind == KIND_NONE) return res;
    if (int'(sec) >= SectorCount) begin
      res.status = ST_NOT_OPEN;
      return res;
    end
    s = find_entry(sec);
    case (kind)
      KIND_OPEN: begin
        if (s >= 0) begin
          if (tbl_marked[s]) begin
            res.status = ST_PENDING;
          end else if (int'(tbl_count[s]) >= MaxCount) begin
            res.status = ST_SATURATED;
          end else begin
            tbl_count[s] = tbl_count[s] + 1'b1;
            res.slot     = s[SlotFieldW-1:0];
          end
        end else begin
          s = find_free_slot();
          if (s < 0) begin
            res.status = ST_FULL;
          end else begin
            tbl_valid[s]  = 1'b1;
            tbl_sector[s] = sec;
            tbl_count[s]  = CountBits'(1);
            tbl_marked[s] = 1'b0;
            res.slot      = s[SlotFieldW-1:0];
          end
        end
      end
      KIND_CLOSE: begin
        if (s < 0) begin
          res.status = ST_NOT_OPEN;
        end else if (tbl_count[s] > 1) begin
          tbl_count[s] = tbl_count[s] - 1'b1;
          res.slot     = s[SlotFieldW-1:0];
        end else begin
          // last close frees the slot and hands back the pending mark
          res.remove_now = tbl_marked[s];
          tbl_valid[s]   = 1'b0;
          res.slot       = s[SlotFieldW-1:0];
        end
      end
      default: begin
        if (s < 0) begin
          res.remove_now = 1'b1;
        end else begin
          tbl_marked[s] = 1'b1;
          res.slot      = s[SlotFieldW-1:0];
        end
      end
    endcase
    return res;
  endfunction

  task automatic report(string what, int exp_v, int got_v);
    $display("mismatch at %0t ns: %s expected %0d, got %0d", $realtime, what, exp_v, got_v);
    errors_o++;
  endtask

  initial begin
    errors_o      = 0;
    waiting_o     = 0;
    status_seen_o = '0;
  end

  always @(posedge clk_i) begin
    outcome_t exp;
    if (!rst_ni) begin
      foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
      outcome_q.delete();
    end else begin
      if (done_i === 1'b1) begin
        if (status_i <= ST_SATURATED) status_seen_o[status_i] = 1'b1;
        if (outcome_q.size() == 0) begin
          report("unrequested result, status", -1, status_i);
        end else begin
          exp = outcome_q.pop_front();
          if (status_i !== exp.status) report("status", exp.status, status_i);
          if (slot_i !== exp.slot) report("slot", exp.slot, slot_i);
          if (remove_now_i !== exp.remove_now) begin
            report("remove_now", exp.remove_now, remove_now_i);
          end
        end
      end
      if (start_i === 1'b1 && busy_i === 1'b0) begin
        outcome_q.push_back(apply_request(kind_e'(kind_i), sector_i));
      end
    end
    waiting_o = outcome_q.size();
  end

endmodule

### test/tb_top.sv
module tb_top;
  import ofrt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ItemTarget  = 950;
  localparam int TailItems   = 100;
  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 40;
  localparam int PoolSize    = 20;

  logic                  clk_i    = 1'b0;
  logic                  rst_ni   = 1'b0;
  logic                  start_i  = 1'b0;
  logic [1:0]            kind_i   = KIND_NONE;
  logic [SectorW-1:0]    sector_i = '0;
  logic                  busy_o;
  logic                  done_o;
  logic [2:0]            status_o;
  logic [SlotFieldW-1:0] slot_o;
  logic                  remove_now_o;

  int                    check_errors;
  int                    results_waiting;
  logic [4:0]            status_seen;
  int                    cycle_no = 0;
  int                    work_items = 0;
  int                    words_sent = 0;
  int                    kind_sent[4] = '{0, 0, 0, 0};
  int                    gap_odds = 2;
  logic [SectorW-1:0]    pool[PoolSize];

  always #6 clk_i = ~clk_i;

  open_file_refcount_table u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .kind_i       (kind_i),
    .sector_i     (sector_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .slot_o       (slot_o),
    .remove_now_o (remove_now_o)
  );

  ofrt_table_check u_table_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_i        (busy_o),
    .kind_i        (kind_i),
    .sector_i      (sector_i),
    .done_i        (done_o),
    .status_i      (status_o),
    .slot_i        (slot_o),
    .remove_now_i  (remove_now_o),
    .errors_o      (check_errors),
    .waiting_o     (results_waiting),
    .status_seen_o (status_seen)
  );

  always @(posedge clk_i) begin
    cycle_no++;
    if (cycle_no > CycleLimit) begin
      $display("timeout after %0d cycles", CycleLimit);
      $display("[open_file_refcount_table] ERROR");
      $finish;
    end
  end

  // drive one word, hold it until taken, then, outside the tail, maybe idle before the next
  task automatic issue(kind_e kind, logic [SectorW-1:0] sec);
    start_i  <= 1'b1;
    kind_i   <= kind;
    sector_i <= sec;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    @(negedge clk_i);
    words_sent++;
    kind_sent[int'(kind)]++;
    if (kind != KIND_NONE) work_items++;
    if (work_items < ItemTarget - TailItems && $urandom_range(0, 7) < gap_odds) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (results_waiting != 0) @(negedge clk_i);
  endtask

  task automatic pool_op(int open_w);
    int r;
    logic [SectorW-1:0] sec;
    r   = $urandom_range(0, 99);
    sec = pool[$urandom_range(0, PoolSize - 1)];
    if (r < open_w) issue(KIND_OPEN, sec);
    else if (r < open_w + 30) issue(KIND_CLOSE, sec);
    else if (r < open_w + 40) issue(KIND_REMOVE, sec);
    else issue(kind_e'($urandom_range(0, 3)), SectorW'($urandom_range(0, SectorCount - 1)));
  endtask

  initial begin
    logic [SectorW-1:0] base;
    logic [SectorW-1:0] sec;
    int n;
    int open_w;

    pool[0] = '0;
    pool[1] = '1;
    for (int i = 2; i < PoolSize; i++) pool[i] = SectorW'($urandom_range(0, SectorCount - 1));

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // directed: insert, reuse of lowest free slot, marking, refused open, last close
    issue(KIND_OPEN, 10'h000);
    issue(KIND_OPEN, 10'h3FF);
    issue(KIND_OPEN, 10'h000);
    issue(KIND_OPEN, 10'h2AA);
    issue(KIND_CLOSE, 10'h3FF);
    issue(KIND_OPEN, 10'h155);
    issue(KIND_REMOVE, 10'h000);
    issue(KIND_REMOVE, 10'h000);
    issue(KIND_OPEN, 10'h000);
    issue(KIND_CLOSE, 10'h000);
    issue(KIND_CLOSE, 10'h000);
    issue(KIND_CLOSE, 10'h000);
    issue(KIND_REMOVE, 10'h3F0);
    issue(KIND_NONE, 10'h3FF);
    issue(KIND_CLOSE, 10'h2AA);
    issue(KIND_CLOSE, 10'h155);
    drain();

    // run one count up to its ceiling, step down and back up again
    for (int i = 0; i < (1 << CountBits); i++) issue(KIND_OPEN, 10'h0F3);
    issue(KIND_OPEN, 10'h0F3);
    issue(KIND_CLOSE, 10'h0F3);
    issue(KIND_OPEN, 10'h0F3);
    issue(KIND_OPEN, 10'h0F3);

    while (work_items < ItemTarget) begin
      gap_odds = $urandom_range(0, 4);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          open_w = $urandom_range(35, 60);
          repeat ($urandom_range(20, 40)) pool_op(open_w);
        end
        5, 6: begin
          // more distinct sectors than slots: the table must fill
          base = SectorW'($urandom_range(0, SectorCount - 1));
          for (int i = 0; i < TableEntries + 2; i++) issue(KIND_OPEN, base + SectorW'(i * 61));
          drain();
          for (int i = 0; i < TableEntries + 2; i++) begin
            if ($urandom_range(0, 3) == 0) issue(KIND_REMOVE, base + SectorW'(i * 61));
            issue(KIND_CLOSE, base + SectorW'(i * 61));
          end
        end
        7, 8: begin
          sec = pool[$urandom_range(0, PoolSize - 1)];
          n   = $urandom_range(1, 3);
          repeat (n) issue(KIND_OPEN, sec);
          issue(KIND_REMOVE, sec);
          issue(KIND_OPEN, sec);
          repeat (n + 1) issue(KIND_CLOSE, sec);
        end
        default: begin
          repeat (8) issue(kind_e'($urandom_range(0, 3)),
                           SectorW'($urandom_range(0, SectorCount - 1)));
        end
      endcase
    end

    drain();
    repeat (DrainCycles) @(negedge clk_i);
    $display("Sent %0d words: %0d open, %0d close, %0d remove, %0d no-op.",
             words_sent, kind_sent[0], kind_sent[1], kind_sent[2], kind_sent[3]);
    $display("Status codes returned (bit per code, ok at bit 0): %b", status_seen);
    if (check_errors == 0) begin
      $display("[open_file_refcount_table] OK");
    end else begin
      $display("[open_file_refcount_table] ERROR");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/ofrt_pkg.sv
hw/rtl/ofrt_front.sv
hw/rtl/ofrt_queue.sv
hw/rtl/ofrt_back.sv
hw/rtl/open_file_refcount_table.sv
test/ofrt_table_check.sv
test/tb_top.sv
